[rtl/core/chamber_thermostat_with_alarms_top_assert.svh]
// Assertion macros used by the chamber thermostat back part.
`ifndef CHAMBER_THERMOSTAT_WITH_ALARMS_TOP_ASSERT_SVH
`define CHAMBER_THERMOSTAT_WITH_ALARMS_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Check a property on every clock edge outside reset.
`define CTHM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Check a property on every clock edge, reset included.
`define CTHM_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define CTHM_ASSERT(lbl, prop, msg)
`define CTHM_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[rtl/core/cthm_pkg.sv]
// Types, constants and register codes of the chamber thermostat.
`default_nettype none
package cthm_pkg;

   localparam int TEMP_W   = 12;
   localparam int OFFS_W   = 9;
   localparam int EDGE_W   = TEMP_W + 1;
   localparam int TIMER_W  = 16;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;
   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   localparam logic [TIMER_W-1:0]       STUCK_DELAY_TICKS = 16'd600;
   localparam logic signed [TEMP_W-1:0] SENSOR_MIN        = -12'sd500;
   localparam logic signed [TEMP_W-1:0] SENSOR_MAX        = 12'sd1500;

   localparam logic signed [TEMP_W-1:0] SETPOINT_RST   = 12'sd40;
   localparam logic [OFFS_W-1:0]        HEAT_OFFS_RST  = 9'd20;
   localparam logic [OFFS_W-1:0]        COOL_OFFS_RST  = 9'd20;
   localparam logic [OFFS_W-1:0]        BAND_BELOW_RST = 9'd10;
   localparam logic [OFFS_W-1:0]        BAND_ABOVE_RST = 9'd10;
   localparam logic signed [TEMP_W-1:0] HIGH_LIMIT_RST = 12'sd150;
   localparam logic signed [TEMP_W-1:0] LOW_LIMIT_RST  = -12'sd100;
   localparam logic [TIMER_W-1:0]       DELAY_RST      = 16'd60;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SETPOINT    = 4'd0,
      CSR_HEAT_OFFSET = 4'd1,
      CSR_COOL_OFFSET = 4'd2,
      CSR_BAND_BELOW  = 4'd3,
      CSR_BAND_ABOVE  = 4'd4,
      CSR_HIGH_LIMIT  = 4'd5,
      CSR_LOW_LIMIT   = 4'd6,
      CSR_ALARM_DELAY = 4'd7
   } csr_index_type;

   typedef enum logic {
      ITEM_SAMPLE = 1'b0,
      ITEM_TICK   = 1'b1
   } item_kind_type;

   // One classified item: raw sample data plus the config compares.
   typedef struct packed {
      item_kind_type           kind;
      logic signed [TEMP_W-1:0] temperature;
      logic auto_select;
      logic system_on;
      logic mode_bit;
      logic heater_available;
      logic cooler_available;
      logic defrost_active;
      logic below_high_limit;   // t <  high limit
      logic at_or_below_low;    // t <= low limit
      logic out_of_range;       // t outside the sensor range
      logic below_lo_edge;      // t <  sp - band_below
      logic above_hi_edge;      // t >  sp + band_above
      logic at_or_below_heat;   // t <= sp - heat_on_offset
      logic at_or_above_cool;   // t >= sp + cool_on_offset
      logic above_lo_edge;      // t >  sp - band_below
      logic below_hi_edge;      // t <  sp + band_above
   } item_type;

   typedef struct packed {
      logic heat_demand;
      logic cool_demand;
      logic prepare_heating;
      logic prepare_cooling;
      logic aeroheater_on;
      logic high_alarm;
      logic low_alarm;
      logic stuck_alarm;
      logic fault_alarm;
      logic any_alarm;
   } result_type;

endpackage
`default_nettype wire

[rtl/core/cthm_fifo.sv]
// Two-entry queue of classified items between the front and back parts.
`default_nettype none
module cthm_fifo
   import cthm_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push_valid,
   output logic          push_ready,
   input  wire item_type push_data,
   output logic          pop_valid,
   input  wire logic     pop_ready,
   output item_type      pop_data
);

   item_type               entries_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]  count_ff, count_in;
   logic                   push, pop;

   assign push_ready = (count_ff != FIFO_CNT_W'(FIFO_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entries_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

[rtl/core/cthm_front.sv]
// Front part: configuration registers, input transfer and item classification.
`default_nettype none
module cthm_front
   import cthm_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [CSR_IDX_W-1:0]    csr_index,
   input  wire logic [CSR_DATA_W-1:0]   csr_data,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic                    req_type,
   input  wire logic signed [TEMP_W-1:0] req_temperature,
   input  wire logic                    req_auto_select,
   input  wire logic                    req_system_on,
   input  wire logic                    req_mode_bit,
   input  wire logic                    req_heater_available,
   input  wire logic                    req_cooler_available,
   input  wire logic                    req_defrost_active,
   output logic                         item_valid,
   input  wire logic                    item_ready,
   output item_type                     item_data,
   output logic [TIMER_W-1:0]           alarm_delay
);

   logic signed [TEMP_W-1:0] setpoint_ff;
   logic [OFFS_W-1:0]        heat_offs_ff, cool_offs_ff, band_below_ff, band_above_ff;
   logic signed [TEMP_W-1:0] high_limit_ff, low_limit_ff;
   logic [TIMER_W-1:0]       delay_ff;

   logic signed [EDGE_W-1:0] t_ext, sp_ext;
   logic signed [EDGE_W-1:0] heat_at, cool_at, lo_edge, hi_edge;

   assign csr_ready   = 1'b1;
   assign alarm_delay = delay_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff   <= SETPOINT_RST;
         heat_offs_ff  <= HEAT_OFFS_RST;
         cool_offs_ff  <= COOL_OFFS_RST;
         band_below_ff <= BAND_BELOW_RST;
         band_above_ff <= BAND_ABOVE_RST;
         high_limit_ff <= HIGH_LIMIT_RST;
         low_limit_ff  <= LOW_LIMIT_RST;
         delay_ff      <= DELAY_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_SETPOINT:    setpoint_ff   <= csr_data[TEMP_W-1:0];
            CSR_HEAT_OFFSET: heat_offs_ff  <= csr_data[OFFS_W-1:0];
            CSR_COOL_OFFSET: cool_offs_ff  <= csr_data[OFFS_W-1:0];
            CSR_BAND_BELOW:  band_below_ff <= csr_data[OFFS_W-1:0];
            CSR_BAND_ABOVE:  band_above_ff <= csr_data[OFFS_W-1:0];
            CSR_HIGH_LIMIT:  high_limit_ff <= csr_data[TEMP_W-1:0];
            CSR_LOW_LIMIT:   low_limit_ff  <= csr_data[TEMP_W-1:0];
            CSR_ALARM_DELAY: delay_ff      <= csr_data[TIMER_W-1:0];
            default: ;
         endcase
      end
   end

   // Widen by one bit so sp +/- offset never wraps.
   assign t_ext   = EDGE_W'(req_temperature);
   assign sp_ext  = EDGE_W'(setpoint_ff);
   assign heat_at = sp_ext - $signed({1'b0, 3'b000, heat_offs_ff});
   assign cool_at = sp_ext + $signed({1'b0, 3'b000, cool_offs_ff});
   assign lo_edge = sp_ext - $signed({1'b0, 3'b000, band_below_ff});
   assign hi_edge = sp_ext + $signed({1'b0, 3'b000, band_above_ff});

   assign req_ready  = item_ready;
   assign item_valid = req_valid;

   always_comb begin
      item_data.kind             = item_kind_type'(req_type);
      item_data.temperature      = req_temperature;
      item_data.auto_select      = req_auto_select;
      item_data.system_on        = req_system_on;
      item_data.mode_bit         = req_mode_bit;
      item_data.heater_available = req_heater_available;
      item_data.cooler_available = req_cooler_available;
      item_data.defrost_active   = req_defrost_active;
      item_data.below_high_limit = (req_temperature < high_limit_ff);
      item_data.at_or_below_low  = (req_temperature <= low_limit_ff);
      item_data.out_of_range     = (req_temperature < SENSOR_MIN) ||
                                   (req_temperature > SENSOR_MAX);
      item_data.below_lo_edge    = (t_ext < lo_edge);
      item_data.above_hi_edge    = (t_ext > hi_edge);
      item_data.at_or_below_heat = (t_ext <= heat_at);
      item_data.at_or_above_cool = (t_ext >= cool_at);
      item_data.above_lo_edge    = (t_ext > lo_edge);
      item_data.below_hi_edge    = (t_ext < hi_edge);
   end

endmodule
`default_nettype wire

[rtl/core/cthm_back.sv]
// Back part: alarm and control state, one item a cycle while results are taken, result register.
`default_nettype none
`include "chamber_thermostat_with_alarms_top_assert.svh"
module cthm_back
   import cthm_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               item_valid,
   output logic                    item_ready,
   input  wire item_type           item_data,
   input  wire logic [TIMER_W-1:0] alarm_delay,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output result_type              rsp_data
);

   logic                     prev_mode_ff, prev_mode_in;
   logic                     was_on_ff, was_on_in;
   logic                     high_armed_ff, high_armed_in;
   logic                     low_armed_ff, low_armed_in;
   logic [TIMER_W-1:0]       limit_timer_ff, limit_timer_in;
   logic [TIMER_W-1:0]       stuck_timer_ff, stuck_timer_in;
   logic signed [TEMP_W-1:0] last_temp_ff, last_temp_in;
   result_type               latch_ff, latch_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     advance;

   assign item_ready = !rsp_valid_ff || rsp_ready;
   assign advance    = item_valid && item_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = latch_ff;

   always_comb begin
      logic changed;
      logic healthy;
      item_type it;
      it             = item_data;
      prev_mode_in   = prev_mode_ff;
      was_on_in      = was_on_ff;
      high_armed_in  = high_armed_ff;
      low_armed_in   = low_armed_ff;
      limit_timer_in = limit_timer_ff;
      stuck_timer_in = stuck_timer_ff;
      last_temp_in   = last_temp_ff;
      latch_in       = latch_ff;
      changed        = (it.mode_bit != prev_mode_ff);
      healthy        = 1'b0;
      case (it.kind)
         ITEM_TICK: begin
            if (limit_timer_ff != '0) limit_timer_in = limit_timer_ff - 1'b1;
            if (stuck_timer_ff != '0) stuck_timer_in = stuck_timer_ff - 1'b1;
         end
         ITEM_SAMPLE: begin
            // Re-arm on a mode change.
            if (changed && !was_on_ff) begin
               high_armed_in = 1'b0;
               low_armed_in  = 1'b0;
            end
            if (changed && !prev_mode_ff) low_armed_in = 1'b0;
            if (changed && prev_mode_ff) high_armed_in = 1'b0;
            was_on_in    = it.system_on;
            prev_mode_in = it.mode_bit;
            if (it.below_high_limit) high_armed_in = 1'b1;
            if (!it.at_or_below_low) low_armed_in = 1'b1;

            // Limit alarms share one timer; the low check sees a reload by the high one.
            latch_in.any_alarm = 1'b0;
            if (!it.defrost_active && high_armed_in) begin
               if (!it.below_high_limit) begin
                  if (limit_timer_in == '0) begin
                     latch_in.high_alarm = 1'b1;
                     latch_in.any_alarm  = 1'b1;
                  end
               end else begin
                  latch_in.high_alarm = 1'b0;
                  limit_timer_in      = alarm_delay;
               end
            end
            if (low_armed_in) begin
               if (it.at_or_below_low) begin
                  if (limit_timer_in == '0) begin
                     latch_in.low_alarm = 1'b1;
                     latch_in.any_alarm = 1'b1;
                  end
               end else begin
                  latch_in.low_alarm = 1'b0;
                  limit_timer_in     = alarm_delay;
               end
            end

            // Stuck sensor.
            if (it.temperature == last_temp_ff) begin
               if (stuck_timer_ff == '0) begin
                  latch_in.stuck_alarm = 1'b1;
                  latch_in.any_alarm   = 1'b1;
               end
            end else begin
               stuck_timer_in       = STUCK_DELAY_TICKS;
               latch_in.stuck_alarm = 1'b0;
            end
            last_temp_in = it.temperature;

            latch_in.fault_alarm = it.out_of_range;
            if (it.out_of_range) latch_in.any_alarm = 1'b1;

            healthy = it.system_on && !latch_in.stuck_alarm && !latch_in.fault_alarm;

            // Equipment requests.
            if (it.auto_select && healthy) begin
               if (it.below_lo_edge) begin
                  latch_in.prepare_cooling = 1'b0;
                  latch_in.prepare_heating = 1'b1;
               end
               if (it.above_hi_edge) begin
                  latch_in.prepare_heating = 1'b0;
                  latch_in.prepare_cooling = 1'b1;
               end
               if (it.at_or_below_heat && it.heater_available)
                  latch_in.heat_demand = 1'b1;
               if (!it.heater_available) latch_in.heat_demand = 1'b0;
               if (it.at_or_above_cool && it.cooler_available)
                  latch_in.cool_demand = 1'b1;
               if (!it.cooler_available) latch_in.cool_demand = 1'b0;
               if (it.above_lo_edge && it.below_hi_edge) begin
                  latch_in.heat_demand = 1'b0;
                  latch_in.cool_demand = 1'b0;
               end
            end else begin
               latch_in.heat_demand     = 1'b0;
               latch_in.cool_demand     = 1'b0;
               latch_in.prepare_heating = 1'b0;
               latch_in.prepare_cooling = 1'b0;
            end

            // Aeroheaters.
            if (healthy) begin
               if (it.at_or_below_heat) latch_in.aeroheater_on = 1'b1;
               if (!it.below_lo_edge) latch_in.aeroheater_on = 1'b0;
            end else begin
               latch_in.aeroheater_on = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_mode_ff   <= 1'b0;
         was_on_ff      <= 1'b0;
         high_armed_ff  <= 1'b0;
         low_armed_ff   <= 1'b0;
         limit_timer_ff <= '0;
         stuck_timer_ff <= '0;
         last_temp_ff   <= '0;
         latch_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            prev_mode_ff   <= prev_mode_in;
            was_on_ff      <= was_on_in;
            high_armed_ff  <= high_armed_in;
            low_armed_ff   <= low_armed_in;
            limit_timer_ff <= limit_timer_in;
            stuck_timer_ff <= stuck_timer_in;
            last_temp_ff   <= last_temp_in;
            latch_ff       <= latch_in;
         end
      end
   end

   `CTHM_ASSERT(a_hold_stalled, rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(latch_ff), "result lost or changed while stalled")
   `CTHM_ASSERT(a_prep_exclusive, !(latch_ff.prepare_heating && latch_ff.prepare_cooling), "both prepare requests set")
   `CTHM_ASSERT(a_unhealthy_off, (latch_ff.stuck_alarm || latch_ff.fault_alarm) |-> !(latch_ff.heat_demand || latch_ff.cool_demand || latch_ff.prepare_heating || latch_ff.prepare_cooling || latch_ff.aeroheater_on), "requests on with a blocking alarm")
   `CTHM_ASSERT(a_tick_keeps_latches, advance && item_data.kind == ITEM_TICK |=> latch_ff == $past(latch_ff), "tick changed a latch")
   `CTHM_ASSERT_ALWAYS(a_reset_idle, reset |=> !rsp_valid_ff, "result pending after reset")

endmodule
`default_nettype wire

[rtl/core/chamber_thermostat_with_alarms_top.sv]
// Top level of the chamber thermostat with hysteresis and alarms.
//
// Channels: req_* carries one item per transfer, either a temperature sample
// (req_type 0) or one timer tick (req_type 1). rsp_* returns exactly one
// result per item, in order: the five request latches, the four alarm
// latches and any_alarm of the latest sample. csr_* writes the eight
// configuration registers by index; csr_ready is always high, and writes
// to unknown indexes are dropped.
// Path: a request is written into the queue; as it leaves the queue the
// item updates the state and loads the result register.
// Throughput: one item per cycle while rsp_ready stays high; the back end's
// state feedback and its result register set that figure.
// Stall: while rsp_ready is low the result holds and the two-entry queue
// keeps taking requests; req_ready drops once the queue is full.
// Reset: synchronous, active high; clears all state and latches and loads
// the register reset values. No results are pending afterward.
`default_nettype none
module chamber_thermostat_with_alarms_top
   import cthm_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [CSR_IDX_W-1:0]     csr_index,
   input  wire logic [CSR_DATA_W-1:0]    csr_data,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic                     req_type,
   input  wire logic signed [TEMP_W-1:0] req_temperature,
   input  wire logic                     req_auto_select,
   input  wire logic                     req_system_on,
   input  wire logic                     req_mode_bit,
   input  wire logic                     req_heater_available,
   input  wire logic                     req_cooler_available,
   input  wire logic                     req_defrost_active,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic                          rsp_heat_demand,
   output logic                          rsp_cool_demand,
   output logic                          rsp_prepare_heating,
   output logic                          rsp_prepare_cooling,
   output logic                          rsp_aeroheater_on,
   output logic                          rsp_high_alarm,
   output logic                          rsp_low_alarm,
   output logic                          rsp_stuck_alarm,
   output logic                          rsp_fault_alarm,
   output logic                          rsp_any_alarm
);

   // Front to queue.
   logic               front_valid, front_ready;
   item_type           front_item;
   logic [TIMER_W-1:0] alarm_delay;
   // Queue to back.
   logic               back_valid, back_ready;
   item_type           back_item;
   result_type         result;

   // Classify samples against the current configuration.
   cthm_front u_front (
      .clock                (clock),
      .reset                (reset),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_type             (req_type),
      .req_temperature      (req_temperature),
      .req_auto_select      (req_auto_select),
      .req_system_on        (req_system_on),
      .req_mode_bit         (req_mode_bit),
      .req_heater_available (req_heater_available),
      .req_cooler_available (req_cooler_available),
      .req_defrost_active   (req_defrost_active),
      .item_valid           (front_valid),
      .item_ready           (front_ready),
      .item_data            (front_item),
      .alarm_delay          (alarm_delay)
   );

   // Decouple classification from the state update.
   cthm_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_data  (front_item),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_data   (back_item)
   );

   // Advance alarm and control state; hold the result until transfer.
   cthm_back u_back (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (back_valid),
      .item_ready  (back_ready),
      .item_data   (back_item),
      .alarm_delay (alarm_delay),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (result)
   );

   assign rsp_heat_demand     = result.heat_demand;
   assign rsp_cool_demand     = result.cool_demand;
   assign rsp_prepare_heating = result.prepare_heating;
   assign rsp_prepare_cooling = result.prepare_cooling;
   assign rsp_aeroheater_on   = result.aeroheater_on;
   assign rsp_high_alarm      = result.high_alarm;
   assign rsp_low_alarm       = result.low_alarm;
   assign rsp_stuck_alarm     = result.stuck_alarm;
   assign rsp_fault_alarm     = result.fault_alarm;
   assign rsp_any_alarm       = result.any_alarm;

endmodule
`default_nettype wire

[verif/tb.sv]
// Self-checking testbench for the chamber thermostat with alarms.
module tb
   import cthm_pkg::*;
();

   // Bench-side view of one request transfer, sample or tick.
   typedef struct {
      item_kind_type            kind;
      logic signed [TEMP_W-1:0] temperature;
      bit                       auto_select;
      bit                       system_on;
      bit                       mode_bit;
      bit                       heater_available;
      bit                       cooler_available;
      bit                       defrost_active;
   } sensor_item_type;

   // Shadow copy of the thermostat: registers, alarm timers and latches.
   // Every accepted item advances it and queues the outputs that the block
   // must return for that item.
   class thermostat_mirror;
      logic signed [TEMP_W-1:0] setpoint;
      logic [OFFS_W-1:0]        heat_offset;
      logic [OFFS_W-1:0]        cool_offset;
      logic [OFFS_W-1:0]        band_below;
      logic [OFFS_W-1:0]        band_above;
      logic signed [TEMP_W-1:0] high_limit;
      logic signed [TEMP_W-1:0] low_limit;
      logic [TIMER_W-1:0]       alarm_delay;

      bit                       prev_mode;
      bit                       was_on;
      bit                       high_armed;
      bit                       low_armed;
      logic [TIMER_W-1:0]       limit_timer;
      logic [TIMER_W-1:0]       stuck_timer;
      logic signed [TEMP_W-1:0] last_temp;
      result_type               latches;

      result_type               due_outputs[$];
      int                       mismatches;

      function new();
         setpoint    = SETPOINT_RST;
         heat_offset = HEAT_OFFS_RST;
         cool_offset = COOL_OFFS_RST;
         band_below  = BAND_BELOW_RST;
         band_above  = BAND_ABOVE_RST;
         high_limit  = HIGH_LIMIT_RST;
         low_limit   = LOW_LIMIT_RST;
         alarm_delay = DELAY_RST;
         prev_mode   = 1'b0;
         was_on      = 1'b0;
         high_armed  = 1'b0;
         low_armed   = 1'b0;
         limit_timer = '0;
         stuck_timer = '0;
         last_temp   = '0;
         latches     = '0;
         mismatches  = 0;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_SETPOINT:    setpoint    = data[TEMP_W-1:0];
            CSR_HEAT_OFFSET: heat_offset = data[OFFS_W-1:0];
            CSR_COOL_OFFSET: cool_offset = data[OFFS_W-1:0];
            CSR_BAND_BELOW:  band_below  = data[OFFS_W-1:0];
            CSR_BAND_ABOVE:  band_above  = data[OFFS_W-1:0];
            CSR_HIGH_LIMIT:  high_limit  = data[TEMP_W-1:0];
            CSR_LOW_LIMIT:   low_limit   = data[TEMP_W-1:0];
            CSR_ALARM_DELAY: alarm_delay = data[TIMER_W-1:0];
            default: ;
         endcase
      endfunction

      function void absorb_item(sensor_item_type it);
         int t;
         int hi;
         int lo;
         int sp;
         int heat_at;
         int cool_at;
         int lo_edge;
         int hi_edge;
         bit changed;
         bit healthy;
         if (it.kind == ITEM_TICK) begin
            if (limit_timer != 0) limit_timer = limit_timer - 1'b1;
            if (stuck_timer != 0) stuck_timer = stuck_timer - 1'b1;
         end else begin
            t  = int'(it.temperature);
            hi = int'(high_limit);
            lo = int'(low_limit);

            // Re-arm on a mode change.
            changed = (it.mode_bit != prev_mode);
            if (changed && !was_on) begin
               high_armed = 1'b0;
               low_armed  = 1'b0;
            end
            was_on = it.system_on;
            if (changed && !prev_mode) low_armed = 1'b0;
            if (changed && prev_mode) high_armed = 1'b0;
            prev_mode = it.mode_bit;
            if (t < hi) high_armed = 1'b1;
            if (t > lo) low_armed = 1'b1;

            // Limit alarms share one delay timer.
            latches.any_alarm = 1'b0;
            if (!it.defrost_active && high_armed) begin
               if (t >= hi) begin
                  if (limit_timer == 0) begin
                     latches.high_alarm = 1'b1;
                     latches.any_alarm  = 1'b1;
                  end
               end else begin
                  latches.high_alarm = 1'b0;
                  limit_timer = alarm_delay;
               end
            end
            if (low_armed) begin
               if (t <= lo) begin
                  if (limit_timer == 0) begin
                     latches.low_alarm = 1'b1;
                     latches.any_alarm = 1'b1;
                  end
               end else begin
                  latches.low_alarm = 1'b0;
                  limit_timer = alarm_delay;
               end
            end

            if (it.temperature == last_temp) begin
               if (stuck_timer == 0) begin
                  latches.stuck_alarm = 1'b1;
                  latches.any_alarm   = 1'b1;
               end
            end else begin
               stuck_timer = STUCK_DELAY_TICKS;
               latches.stuck_alarm = 1'b0;
            end
            last_temp = it.temperature;

            if (t < int'(SENSOR_MIN) || t > int'(SENSOR_MAX)) begin
               latches.fault_alarm = 1'b1;
               latches.any_alarm   = 1'b1;
            end else begin
               latches.fault_alarm = 1'b0;
            end

            // Control against the setpoint at full precision.
            sp      = int'(setpoint);
            heat_at = sp - int'(heat_offset);
            cool_at = sp + int'(cool_offset);
            lo_edge = sp - int'(band_below);
            hi_edge = sp + int'(band_above);
            healthy = it.system_on && !latches.stuck_alarm && !latches.fault_alarm;

            if (it.auto_select && healthy) begin
               if (t < lo_edge) begin
                  latches.prepare_cooling = 1'b0;
                  latches.prepare_heating = 1'b1;
               end
               if (t > hi_edge) begin
                  latches.prepare_heating = 1'b0;
                  latches.prepare_cooling = 1'b1;
               end
               if (t <= heat_at && it.heater_available) latches.heat_demand = 1'b1;
               if (!it.heater_available) latches.heat_demand = 1'b0;
               if (t >= cool_at && it.cooler_available) latches.cool_demand = 1'b1;
               if (!it.cooler_available) latches.cool_demand = 1'b0;
               if (t > lo_edge && t < hi_edge) begin
                  latches.heat_demand = 1'b0;
                  latches.cool_demand = 1'b0;
               end
            end else begin
               latches.heat_demand     = 1'b0;
               latches.cool_demand     = 1'b0;
               latches.prepare_heating = 1'b0;
               latches.prepare_cooling = 1'b0;
            end

            if (healthy) begin
               if (t <= heat_at) latches.aeroheater_on = 1'b1;
               if (t >= lo_edge) latches.aeroheater_on = 1'b0;
            end else begin
               latches.aeroheater_on = 1'b0;
            end
         end
         due_outputs.push_back(latches);
      endfunction

      function void check_outputs(result_type got);
         result_type want;
         int i;
         string names [10] = '{"heat_demand", "cool_demand", "prepare_heating",
                               "prepare_cooling", "aeroheater_on", "high_alarm",
                               "low_alarm", "stuck_alarm", "fault_alarm", "any_alarm"};
         if (due_outputs.size() == 0) begin
            $display("%0t unexpected result: expected none, actual %b", $time, got);
            mismatches++;
         end else begin
            want = due_outputs.pop_front();
            for (i = 0; i < $bits(result_type); i++) begin
               if (want[$bits(result_type)-1-i] !== got[$bits(result_type)-1-i]) begin
                  $display("%0t mismatch on %s: expected %0b actual %0b", $time, names[i],
                           want[$bits(result_type)-1-i], got[$bits(result_type)-1-i]);
                  mismatches++;
               end
            end
         end
      endfunction
   endclass

   localparam int IDLE_SETTLE = 4;
   // Idle limit for each side, drawn afresh for every item.
   localparam int IDLE_MAX    = 10;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index = '0;
   logic [CSR_DATA_W-1:0]    csr_data = '0;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic                     req_type = 1'b0;
   logic signed [TEMP_W-1:0] req_temperature = '0;
   logic                     req_auto_select = 1'b0;
   logic                     req_system_on = 1'b0;
   logic                     req_mode_bit = 1'b0;
   logic                     req_heater_available = 1'b0;
   logic                     req_cooler_available = 1'b0;
   logic                     req_defrost_active = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic                     rsp_heat_demand;
   logic                     rsp_cool_demand;
   logic                     rsp_prepare_heating;
   logic                     rsp_prepare_cooling;
   logic                     rsp_aeroheater_on;
   logic                     rsp_high_alarm;
   logic                     rsp_low_alarm;
   logic                     rsp_stuck_alarm;
   logic                     rsp_fault_alarm;
   logic                     rsp_any_alarm;

   thermostat_mirror mirror = new();

   // Temperature region of the current random run and the items left in it.
   int temp_region = 0;
   int run_left    = 0;
   bit cur_mode    = 1'b0;

   chamber_thermostat_with_alarms_top u_top (.*);

   always #5 clock = ~clock;

   // Pack an item; flags are {auto_select, system_on, mode_bit,
   // heater_available, cooler_available, defrost_active}.
   function automatic sensor_item_type build_item(item_kind_type kind, int t, bit [5:0] flags);
      sensor_item_type it;
      it.kind             = kind;
      it.temperature      = TEMP_W'(t);
      it.auto_select      = flags[5];
      it.system_on        = flags[4];
      it.mode_bit         = flags[3];
      it.heater_available = flags[2];
      it.cooler_available = flags[1];
      it.defrost_active   = flags[0];
      return it;
   endfunction

   // Draw one random item. Temperatures stay in one region for a run of
   // items so that limit conditions persist long enough for the delay to
   // expire; the anchors follow the registers now programmed.
   function automatic sensor_item_type draw_item();
      int t;
      int sp;
      int anchors [5];
      bit [5:0] flags;
      item_kind_type kind;
      if (run_left == 0) begin
         temp_region = int'($urandom_range(4, 0));
         run_left    = int'($urandom_range(20, 4));
      end
      run_left--;
      sp = int'(mirror.setpoint);
      anchors[0] = sp - int'(mirror.heat_offset);
      anchors[1] = sp + int'(mirror.cool_offset);
      anchors[2] = sp - int'(mirror.band_below);
      anchors[3] = sp + int'(mirror.band_above);
      anchors[4] = sp;
      case (temp_region)
         0: t = anchors[$urandom_range(4, 0)] + int'($urandom_range(6, 0)) - 3;
         1: t = int'(mirror.high_limit) + int'($urandom_range(8, 0)) - 4;
         2: t = int'(mirror.low_limit) + int'($urandom_range(8, 0)) - 4;
         3: t = (($urandom_range(1, 0) == 0) ? int'(SENSOR_MIN) : int'(SENSOR_MAX))
                + int'($urandom_range(4, 0)) - 2;
         default: t = int'($urandom);
      endcase
      if ($urandom_range(9, 0) == 0) t = int'(mirror.last_temp);
      if ($urandom_range(99, 0) < 8) cur_mode = ~cur_mode;
      flags[5] = ($urandom_range(99, 0) < 85);
      flags[4] = ($urandom_range(99, 0) < 88);
      flags[3] = cur_mode;
      flags[2] = ($urandom_range(99, 0) < 85);
      flags[1] = ($urandom_range(99, 0) < 85);
      flags[0] = ($urandom_range(99, 0) < 15);
      kind = ($urandom_range(99, 0) < 30) ? ITEM_TICK : ITEM_SAMPLE;
      return build_item(kind, t, flags);
   endfunction

   // Present one item and hold it until the transfer; valid stays high when
   // the next item follows with no gap.
   task automatic send_item(input sensor_item_type it);
      int gap;
      gap = int'($urandom_range(IDLE_MAX, 0));
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid            <= 1'b1;
      req_type             <= it.kind;
      req_temperature      <= it.temperature;
      req_auto_select      <= it.auto_select;
      req_system_on        <= it.system_on;
      req_mode_bit         <= it.mode_bit;
      req_heater_available <= it.heater_available;
      req_cooler_available <= it.cooler_available;
      req_defrost_active   <= it.defrost_active;
      do @(posedge clock); while (req_ready !== 1'b1);
      mirror.absorb_item(it);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      mirror.write_register(idx, data);
   endtask

   // Fill the bits above a register's width with noise; the block must drop them.
   function automatic logic [CSR_DATA_W-1:0] pad_upper(int v, int w);
      int mask;
      mask = (1 << w) - 1;
      return CSR_DATA_W'((int'($urandom) & ~mask) | (v & mask));
   endfunction

   task automatic program_registers(input int sp, input int heat, input int cool,
                                    input int below, input int above, input int hi,
                                    input int lo, input int delay);
      csr_write(CSR_SETPOINT,    pad_upper(sp, TEMP_W));
      csr_write(CSR_HEAT_OFFSET, pad_upper(heat, OFFS_W));
      csr_write(CSR_COOL_OFFSET, pad_upper(cool, OFFS_W));
      csr_write(CSR_BAND_BELOW,  pad_upper(below, OFFS_W));
      csr_write(CSR_BAND_ABOVE,  pad_upper(above, OFFS_W));
      csr_write(CSR_HIGH_LIMIT,  pad_upper(hi, TEMP_W));
      csr_write(CSR_LOW_LIMIT,   pad_upper(lo, TEMP_W));
      csr_write(CSR_ALARM_DELAY, CSR_DATA_W'(delay));
      // An index past the register map must leave every register alone.
      csr_write(CSR_IDX_W'($urandom_range((1 << CSR_IDX_W) - 1, int'(CSR_ALARM_DELAY) + 1)),
                CSR_DATA_W'($urandom));
      csr_valid <= 1'b0;
   endtask

   // Optionally age both timers with a long tick run first, then revisit
   // the last value so the stuck-sensor alarm can fire.
   task automatic run_random(input int count, input int tick_burst);
      int n;
      if (tick_burst > 0) begin
         for (n = 0; n < tick_burst; n++)
            send_item(build_item(ITEM_TICK, int'($urandom), 6'($urandom)));
         send_item(build_item(ITEM_SAMPLE, int'(mirror.last_temp), 6'b110110));
      end
      for (n = 0; n < count; n++)
         send_item(draw_item());
      req_valid <= 1'b0;
   endtask

   // Wait until every expected result has arrived, then let the pipe settle.
   task automatic wait_idle();
      while (mirror.due_outputs.size() != 0) @(posedge clock);
      repeat (IDLE_SETTLE) @(posedge clock);
   endtask

   // Result side: stall a random number of cycles before each transfer,
   // then hold ready until the block presents a result.
   initial begin
      int stall;
      forever begin
         stall = int'($urandom_range(IDLE_MAX, 0));
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1 || reset);
         mirror.check_outputs({rsp_heat_demand, rsp_cool_demand, rsp_prepare_heating,
                               rsp_prepare_cooling, rsp_aeroheater_on, rsp_high_alarm,
                               rsp_low_alarm, rsp_stuck_alarm, rsp_fault_alarm,
                               rsp_any_alarm});
      end
   end

   initial begin
      sensor_item_type directed_q[$];
      int phase;
      int sp;

      // Hold reset high from the start, then release it once.
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed pass with the reset registers: setpoint 40, heating at or
      // below 20, cooling at or above 60, dead band 30..50, limits 150/-100.
      // The first sample repeats the cleared last value with a spent stuck
      // timer, so the stuck alarm fires at once and blocks control.
      directed_q.push_back(build_item(ITEM_SAMPLE, 0, 6'b110110));
      directed_q.push_back(build_item(ITEM_SAMPLE, 2047, 6'b110110));
      directed_q.push_back(build_item(ITEM_SAMPLE, -2048, 6'b110110));
      directed_q.push_back(build_item(ITEM_SAMPLE, -501, 6'b110110));
      directed_q.push_back(build_item(ITEM_SAMPLE, -500, 6'b110110));
      directed_q.push_back(build_item(ITEM_SAMPLE, 1500, 6'b110110));
      directed_q.push_back(build_item(ITEM_SAMPLE, 1501, 6'b110110));
      // Walk through heating, hold, aeroheater release, dead band, cooling.
      directed_q.push_back(build_item(ITEM_SAMPLE, 10, 6'b110110));
      directed_q.push_back(build_item(ITEM_SAMPLE, 25, 6'b110110));
      directed_q.push_back(build_item(ITEM_SAMPLE, 30, 6'b110110));
      directed_q.push_back(build_item(ITEM_SAMPLE, 40, 6'b110110));
      directed_q.push_back(build_item(ITEM_SAMPLE, 70, 6'b110110));
      // Equipment drops out, then automatic control is deselected.
      directed_q.push_back(build_item(ITEM_SAMPLE, 71, 6'b110100));
      directed_q.push_back(build_item(ITEM_SAMPLE, 10, 6'b110010));
      directed_q.push_back(build_item(ITEM_SAMPLE, 11, 6'b010110));
      // Mode change while on, then a change back while off: re-arm paths.
      directed_q.push_back(build_item(ITEM_SAMPLE, 150, 6'b101110));
      directed_q.push_back(build_item(ITEM_SAMPLE, 155, 6'b100110));
      directed_q.push_back(build_item(ITEM_SAMPLE, 160, 6'b110111));
      directed_q.push_back(build_item(ITEM_TICK, 0, 6'b000000));
      directed_q.push_back(build_item(ITEM_SAMPLE, -100, 6'b110110));
      directed_q.push_back(build_item(ITEM_SAMPLE, -120, 6'b110110));
      directed_q.push_back(build_item(ITEM_TICK, -1, 6'b111111));
      foreach (directed_q[i]) send_item(directed_q[i]);
      req_valid <= 1'b0;
      wait_idle();

      // Extremes: widest offsets, limits at the ends, longest delay.
      program_registers(-2048, 511, 511, 511, 511, 2047, -2048, 65535);
      run_random(25, 0);
      wait_idle();

      // Opposite extremes: no offsets, inverted limits, no delay.
      program_registers(2047, 0, 0, 0, 0, -2048, 2047, 0);
      run_random(25, 0);

      // Random settings with short delays; one phase ages the stuck timer.
      for (phase = 0; phase < 8; phase++) begin
         wait_idle();
         sp = int'($urandom_range(600, 0)) - 300;
         program_registers(sp, int'($urandom_range(80, 0)), int'($urandom_range(80, 0)),
                           int'($urandom_range(80, 0)), int'($urandom_range(80, 0)),
                           sp + int'($urandom_range(300, 40)),
                           sp - int'($urandom_range(300, 40)),
                           int'($urandom_range(8, 0)));
         run_random(22, (phase == 3) ? int'(STUCK_DELAY_TICKS) + 5 : 0);
      end
      wait_idle();

      if (mirror.mismatches == 0 && mirror.due_outputs.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #2000000;
      $display("%0t timeout", $time);
      $display("status: fail");
      $finish;
   end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/cthm_pkg.sv
rtl/core/cthm_fifo.sv
rtl/core/cthm_front.sv
rtl/core/cthm_back.sv
rtl/core/chamber_thermostat_with_alarms_top.sv
verif/tb.sv
